>>> hw/rtl/cme_pkg.sv
package cme_pkg;

   // Command codes of the request channel
   typedef enum logic [2:0] {
      CMD_RESTART = 3'd0,
      CMD_MAP     = 3'd1,
      CMD_UINT    = 3'd2,
      CMD_SINT    = 3'd3,
      CMD_BOOL    = 3'd4,
      CMD_BYTES   = 3'd5,
      CMD_TEXT    = 3'd6,
      CMD_PAYLOAD = 3'd7
   } cmd_type;

   // CBOR major types
   localparam logic [2:0] MAJ_UINT = 3'd0;
   localparam logic [2:0] MAJ_NINT = 3'd1;
   localparam logic [2:0] MAJ_BSTR = 3'd2;
   localparam logic [2:0] MAJ_TSTR = 3'd3;
   localparam logic [2:0] MAJ_MAP  = 3'd5;

   // Additional-info codes for 1, 2, 4 and 8 argument bytes
   localparam logic [4:0] AI_ARG1 = 5'd24;
   localparam logic [4:0] AI_ARG2 = 5'd25;
   localparam logic [4:0] AI_ARG4 = 5'd26;
   localparam logic [4:0] AI_ARG8 = 5'd27;
   localparam logic [4:0] AI_DIRECT_MAX = 5'd23;

   // Boolean bytes
   localparam logic [7:0] CBOR_FALSE = 8'hf4;
   localparam logic [7:0] CBOR_TRUE  = 8'hf5;

   localparam logic [15:0] CAPACITY_RESET = 16'd4096;
   localparam int QUEUE_DEPTH_DEF = 2;

   // One encoded head: initial byte, count of argument bytes, and the
   // argument left-aligned so the first byte to send sits in [63:56]
   typedef struct packed {
      logic [7:0]  head;
      logic [3:0]  len;
      logic [63:0] arg_sh;
   } head_type;

   // Work descriptor handed from the front end to the byte sequencer
   typedef struct packed {
      logic        restart;
      logic        has_key;
      logic [7:0]  key_head;
      logic [3:0]  key_len;
      logic [31:0] key_sh;
      logic [7:0]  val_head;
      logic [3:0]  val_len;
      logic [63:0] val_sh;
   } desc_type;

   // Shortest-form head for a major type and argument
   function automatic head_type make_head(logic [2:0] major, logic [63:0] arg);
      head_type h;
      h.arg_sh = '0;
      if (arg <= {59'd0, AI_DIRECT_MAX}) begin
         h.head = {major, arg[4:0]};
         h.len  = 4'd0;
      end else if (arg <= 64'h0000_0000_0000_00ff) begin
         h.head   = {major, AI_ARG1};
         h.len    = 4'd1;
         h.arg_sh = {arg[7:0], 56'd0};
      end else if (arg <= 64'h0000_0000_0000_ffff) begin
         h.head   = {major, AI_ARG2};
         h.len    = 4'd2;
         h.arg_sh = {arg[15:0], 48'd0};
      end else if (arg <= 64'h0000_0000_ffff_ffff) begin
         h.head   = {major, AI_ARG4};
         h.len    = 4'd4;
         h.arg_sh = {arg[31:0], 32'd0};
      end else begin
         h.head   = {major, AI_ARG8};
         h.len    = 4'd8;
         h.arg_sh = arg;
      end
      return h;
   endfunction

endpackage

>>> hw/rtl/cme_front.sv
module cme_front (
   input  logic [2:0]         req_cmd,
   input  logic [31:0]        req_key,
   input  logic [63:0]        req_value,
   input  logic signed [31:0] req_signed_value,
   input  logic               req_flag,
   input  logic [7:0]         req_data_byte,
   output cme_pkg::desc_type  desc
);
   import cme_pkg::*;

   head_type    key_h;
   head_type    val_h;
   logic [31:0] sv;

   assign sv    = unsigned'(req_signed_value);
   assign key_h = make_head(MAJ_UINT, {32'd0, req_key});

   // Classify the command into a restart, or an optional key head plus one value head or raw byte
   always_comb begin
      val_h = '0;
      desc  = '0;
      unique case (cmd_type'(req_cmd))
         CMD_RESTART: begin
            desc.restart = 1'b1;
         end
         CMD_MAP: begin
            val_h = make_head(MAJ_MAP, req_value);
         end
         CMD_UINT: begin
            desc.has_key = 1'b1;
            val_h = make_head(MAJ_UINT, req_value);
         end
         CMD_SINT: begin
            desc.has_key = 1'b1;
            // negative values carry -1 - v, which is the bitwise inverse
            if (sv[31]) begin
               val_h = make_head(MAJ_NINT, {32'd0, ~sv});
            end else begin
               val_h = make_head(MAJ_UINT, {32'd0, sv});
            end
         end
         CMD_BOOL: begin
            desc.has_key = 1'b1;
            val_h.head = req_flag ? CBOR_TRUE : CBOR_FALSE;
         end
         CMD_BYTES: begin
            desc.has_key = 1'b1;
            val_h = make_head(MAJ_BSTR, req_value);
         end
         CMD_TEXT: begin
            desc.has_key = 1'b1;
            val_h = make_head(MAJ_TSTR, req_value);
         end
         CMD_PAYLOAD: begin
            val_h.head = req_data_byte;
         end
         default: begin
            desc.restart = 1'b1;
         end
      endcase
      desc.key_head = key_h.head;
      desc.key_len  = key_h.len;
      desc.key_sh   = key_h.arg_sh[63:32];
      desc.val_head = val_h.head;
      desc.val_len  = val_h.len;
      desc.val_sh   = val_h.arg_sh;
   end

endmodule

>>> hw/rtl/cme_queue.sv
module cme_queue #(
   parameter int DEPTH = cme_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cme_pkg::desc_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output cme_pkg::desc_type pop_data
);
   import cme_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   desc_type        mem [DEPTH];
   logic [IW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/cme_back.sv
module cme_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              q_not_empty,
   input  cme_pkg::desc_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last,
   output logic              rsp_status,
   output logic [15:0]       rsp_bytes_used
);
   import cme_pkg::*;

   typedef enum logic [3:0] {
      PH_KHEAD = 4'b0001,
      PH_KARG  = 4'b0010,
      PH_VHEAD = 4'b0100,
      PH_VARG  = 4'b1000
   } phase_type;

   logic [15:0] capacity_ff;
   logic [15:0] wcount_ff, wcount_in;
   logic        cur_valid_ff, cur_valid_in;
   desc_type    cur_ff, cur_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] key_sh_ff, key_sh_in;
   logic [63:0] val_sh_ff, val_sh_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        byte_valid_ff, byte_valid_in;
   logic        last_ff, last_in;
   logic        status_ff, status_in;
   logic [15:0] used_ff, used_in;

   logic        out_free;
   logic        advance;
   logic        done;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = cur_valid_ff && out_free;
   assign q_pop    = q_not_empty && (!cur_valid_ff || done);

   // Byte sequencer: one result per cycle while the output register is free
   always_comb begin
      wcount_in     = wcount_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      key_sh_in     = key_sh_ff;
      val_sh_in     = val_sh_ff;
      done          = 1'b0;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      used_in       = used_ff;
      if (advance) begin
         out_byte_in   = '0;
         byte_valid_in = 1'b0;
         last_in       = 1'b1;
         status_in     = 1'b0;
         if (cur_ff.restart) begin
            wcount_in = '0;
            done      = 1'b1;
         end else if (wcount_ff >= capacity_ff) begin
            // buffer full: one terminating status result
            status_in = 1'b1;
            done      = 1'b1;
         end else begin
            wcount_in     = wcount_ff + 16'd1;
            byte_valid_in = 1'b1;
            last_in       = 1'b0;
            unique case (phase_ff)
               PH_KHEAD: begin
                  out_byte_in = cur_ff.key_head;
                  cnt_in      = cur_ff.key_len;
                  phase_in    = (cur_ff.key_len == 4'd0) ? PH_VHEAD : PH_KARG;
               end
               PH_KARG: begin
                  out_byte_in = key_sh_ff[31:24];
                  key_sh_in   = {key_sh_ff[23:0], 8'd0};
                  cnt_in      = cnt_ff - 4'd1;
                  if (cnt_ff == 4'd1) begin
                     phase_in = PH_VHEAD;
                  end
               end
               PH_VHEAD: begin
                  out_byte_in = cur_ff.val_head;
                  cnt_in      = cur_ff.val_len;
                  phase_in    = PH_VARG;
                  last_in     = (cur_ff.val_len == 4'd0);
               end
               PH_VARG: begin
                  out_byte_in = val_sh_ff[63:56];
                  val_sh_in   = {val_sh_ff[55:0], 8'd0};
                  cnt_in      = cnt_ff - 4'd1;
                  last_in     = (cnt_ff == 4'd1);
               end
               default: begin
                  out_byte_in = cur_ff.val_head;
                  last_in     = 1'b1;
               end
            endcase
            done = last_in;
         end
         used_in = wcount_in;
      end
   end

   // Descriptor load, overlapping the final byte of the previous one
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_data;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         wcount_ff    <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_VHEAD;
         cnt_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         wcount_ff    <= wcount_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff <= q_data.has_key ? PH_KHEAD : PH_VHEAD;
            cnt_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      key_sh_ff     <= q_pop ? q_data.key_sh : key_sh_in;
      val_sh_ff     <= q_pop ? q_data.val_sh : val_sh_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      used_ff       <= used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_ff;
   assign rsp_bytes_used = used_ff;

endmodule

>>> hw/rtl/cbor_map_field_encoder_core.sv
// CBOR map field encoder.
// Request channel (req_valid / req_stall): one command per transaction;
// restart, map head, key plus unsigned / signed / bool / string head, or one
// raw payload byte. Result channel (rsp_valid / rsp_stall): one transaction
// per written byte, or one status-only result on restart or a full buffer;
// rsp_last marks the final result of a command.
// csr_wr_en / csr_wr_data write the 16-bit buffer capacity (reset 4096).
// After a command is accepted it passes the descriptor queue, the sequencer
// load and the output register before its first result shows rsp_valid.
// The byte sequencer emits one result per cycle while the output register is
// free; a command yields 1 to 14 results (its head bytes). The next command's
// descriptor loads alongside the final result of the previous one, and the
// request side accepts until the descriptor queue (QUEUE_DEPTH entries) fills.
// Reset clears the byte count and the queue and restores the capacity.
// A stalled result holds in the output register; the sequencer then waits,
// the queue fills and req_stall rises.
module cbor_map_field_encoder_core #(
   parameter int QUEUE_DEPTH = cme_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [31:0]        req_key,
   input  logic [63:0]        req_value,
   input  logic signed [31:0] req_signed_value,
   input  logic               req_flag,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_last,
   output logic               rsp_status,
   output logic [15:0]        rsp_bytes_used
);
   import cme_pkg::*;

   desc_type front_desc;
   desc_type q_data;
   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_not_empty;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   cme_front u_front (
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_value        (req_value),
      .req_signed_value (req_signed_value),
      .req_flag         (req_flag),
      .req_data_byte    (req_data_byte),
      .desc             (front_desc)
   );

   cme_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_desc),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   cme_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .q_not_empty    (q_not_empty),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .rsp_bytes_used (rsp_bytes_used)
   );

   // A full-buffer result always ends its command
   a_status_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && !rsp_byte_valid)
      else $error("status result not marked last");

   // A result without a byte and without status is a restart: count is zero
   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid && !rsp_status |-> rsp_bytes_used == 16'd0)
      else $error("restart result with nonzero count");

   // A written byte is never reported with the full status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_status)
      else $error("byte result flagged full");

   // The sequencer only takes a descriptor the queue holds
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("queue popped while empty");

endmodule
